// ----- rtl/fault_qualifier_heal_latch_top_assert.svh -----
// assertion macros for the fault qualifier block
`ifndef FAULT_QUALIFIER_HEAL_LATCH_TOP_ASSERT_SVH
`define FAULT_QUALIFIER_HEAL_LATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define FQHL_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fqhl assertion failed");
`define FQHL_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fqhl assertion failed");
`else
`define FQHL_ASSERT_IMP(label, a, b)
`define FQHL_ASSERT_NXT(label, a, b)
`endif

`endif

// ----- rtl/fqhl_pkg.sv -----
// package: types, codes and constants of the fault qualifier block
`timescale 1ns / 1ps

package fqhl_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] STATUS_OK             = 2'd0;
    localparam logic [1:0] STATUS_NOT_CONFIGURED = 2'd1;
    localparam logic [1:0] STATUS_INVALID_CYCLES = 2'd2;

    localparam logic [1:0] FAULT_ABSENT    = 2'd0;
    localparam logic [1:0] FAULT_PENDING   = 2'd1;
    localparam logic [1:0] FAULT_CONFIRMED = 2'd2;
    localparam logic [1:0] FAULT_HEALING   = 2'd3;

    localparam logic [1:0] REG_CONFIRM_LIMIT = 2'd0;
    localparam logic [1:0] REG_HEAL_LIMIT    = 2'd1;
    localparam logic [1:0] REG_LATCH_ENABLE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        present;
        logic [31:0] cycles;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  fault_state;
        logic        is_confirmed;
        logic        is_active;
        logic [31:0] progress_count;
        logic [31:0] occurrence_total;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_wr_t;

endpackage

// ----- rtl/fqhl_core.sv -----
// qualification state, configuration registers and next-state logic
`timescale 1ns / 1ps
`include "fault_qualifier_heal_latch_top_assert.svh"

module fqhl_core #(
    parameter int COUNT_WIDTH = fqhl_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fqhl_pkg::cfg_wr_t cfg_wr,
    input  logic              accept,
    input  fqhl_pkg::item_t   item,
    output fqhl_pkg::result_t result
);

    localparam int AW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

    typedef enum logic [3:0] {
        Q_ABSENT    = 4'b0001,
        Q_PENDING   = 4'b0010,
        Q_CONFIRMED = 4'b0100,
        Q_HEALING   = 4'b1000
    } qual_state_t;

    logic [31:0]            confirm_limit_reg;
    logic [31:0]            heal_limit_reg;
    logic                   latch_enable_reg;
    qual_state_t            state_reg;
    qual_state_t            state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] occ_reg;
    logic [COUNT_WIDTH-1:0] occ_next;
    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] add_sat;
    logic [COUNT_WIDTH-1:0] occ_inc;
    logic [AW-1:0]          sum_ext;
    logic [AW-1:0]          max_ext;
    logic [AW-1:0]          sat_ext;
    logic [AW-1:0]          cnt_next_ext;
    logic [AW-1:0]          occ_next_ext;
    logic                   confirm_hit;
    logic                   heal_hit;
    logic                   configured;
    logic [1:0]             status;
    logic [1:0]             fault_code;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_limit_reg <= '0;
            heal_limit_reg    <= '0;
            latch_enable_reg  <= 1'b0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                fqhl_pkg::REG_CONFIRM_LIMIT: confirm_limit_reg <= cfg_wr.data;
                fqhl_pkg::REG_HEAL_LIMIT:    heal_limit_reg    <= cfg_wr.data;
                fqhl_pkg::REG_LATCH_ENABLE:  latch_enable_reg  <= cfg_wr.data[0];
                default: ;
            endcase
        end
    end

    // one saturating adder shared by pending and healing counts
    assign base    = (state_reg == Q_PENDING || state_reg == Q_HEALING) ? cnt_reg : '0;
    assign sum_ext = {{(AW-COUNT_WIDTH){1'b0}}, base} + {{(AW-32){1'b0}}, item.cycles};
    assign max_ext = {{(AW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    assign add_sat = (sum_ext > max_ext) ? {COUNT_WIDTH{1'b1}} : sum_ext[COUNT_WIDTH-1:0];
    assign sat_ext = {{(AW-COUNT_WIDTH){1'b0}}, add_sat};
    assign confirm_hit = sat_ext >= {{(AW-32){1'b0}}, confirm_limit_reg};
    assign heal_hit    = sat_ext >= {{(AW-32){1'b0}}, heal_limit_reg};
    assign occ_inc     = (occ_reg == {COUNT_WIDTH{1'b1}}) ? occ_reg
                         : occ_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign configured  = (confirm_limit_reg != '0) && (heal_limit_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        occ_next   = occ_reg;
        status     = fqhl_pkg::STATUS_OK;
        if (item.operation != fqhl_pkg::OP_NONE)
        begin
            if (!configured)
            begin
                status = fqhl_pkg::STATUS_NOT_CONFIGURED;
            end
            else if (item.operation == fqhl_pkg::OP_UPDATE)
            begin
                if (item.cycles == '0)
                begin
                    status = fqhl_pkg::STATUS_INVALID_CYCLES;
                end
                else if (item.present)
                begin
                    if (state_reg == Q_CONFIRMED || state_reg == Q_HEALING)
                    begin
                        state_next = Q_CONFIRMED;
                        cnt_next   = '0;
                    end
                    else if (confirm_hit)
                    begin
                        state_next = Q_CONFIRMED;
                        cnt_next   = '0;
                        occ_next   = occ_inc;
                    end
                    else
                    begin
                        state_next = Q_PENDING;
                        cnt_next   = add_sat;
                    end
                end
                else
                begin
                    case (state_reg)
                        Q_CONFIRMED:
                        begin
                            if (latch_enable_reg)
                            begin
                                cnt_next = '0;
                            end
                            else if (heal_hit)
                            begin
                                state_next = Q_ABSENT;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                state_next = Q_HEALING;
                                cnt_next   = add_sat;
                            end
                        end
                        Q_HEALING:
                        begin
                            if (heal_hit)
                            begin
                                state_next = Q_ABSENT;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                cnt_next = add_sat;
                            end
                        end
                        default:
                        begin
                            state_next = Q_ABSENT;
                            cnt_next   = '0;
                        end
                    endcase
                end
            end
            else
            begin
                state_next = Q_ABSENT;
                cnt_next   = '0;
                if (item.operation == fqhl_pkg::OP_RESET)
                begin
                    occ_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_ABSENT;
            cnt_reg   <= '0;
            occ_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            occ_reg   <= occ_next;
        end
    end

    always_comb
    begin
        case (state_next)
            Q_ABSENT:    fault_code = fqhl_pkg::FAULT_ABSENT;
            Q_PENDING:   fault_code = fqhl_pkg::FAULT_PENDING;
            Q_CONFIRMED: fault_code = fqhl_pkg::FAULT_CONFIRMED;
            Q_HEALING:   fault_code = fqhl_pkg::FAULT_HEALING;
            default:     fault_code = fqhl_pkg::FAULT_ABSENT;
        endcase
    end

    assign cnt_next_ext = {{(AW-COUNT_WIDTH){1'b0}}, cnt_next};
    assign occ_next_ext = {{(AW-COUNT_WIDTH){1'b0}}, occ_next};

    assign result.status           = status;
    assign result.fault_state      = fault_code;
    assign result.is_confirmed     = (state_next == Q_CONFIRMED) || (state_next == Q_HEALING);
    assign result.is_active        = (state_next == Q_PENDING) || (state_next == Q_CONFIRMED);
    assign result.progress_count   = cnt_next_ext[31:0];
    assign result.occurrence_total = occ_next_ext[31:0];

    `FQHL_ASSERT_IMP(a_cnt_zero_when_idle,
        (state_reg == Q_ABSENT || state_reg == Q_CONFIRMED), (cnt_reg == '0))
    `FQHL_ASSERT_IMP(a_pending_cnt_nonzero, (state_reg == Q_PENDING), (cnt_reg != '0))
    `FQHL_ASSERT_NXT(a_unconfigured_holds, (accept && !configured),
        ($stable(state_reg) && $stable(cnt_reg) && $stable(occ_reg)))

endmodule

// ----- rtl/fault_qualifier_heal_latch_top.sv -----
// top level of the fault qualifier with heal and latch
//
// channel  direction  handshake             payload
// item     in         item_valid/item_stall fqhl_pkg::item_t
// result   out        result_valid/stall    fqhl_pkg::result_t
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one request per cycle while item_stall is low; its result is registered into the output register, or into the skid
// register while the output is stalled; the next-state logic is one saturating add and two compares on its sum
// reset clears state, counters and limits; limits read as zero, so status is not configured
// a stalled result stays put, and a skid register takes one more request behind it
// item_stall rises only while the skid register is full
`timescale 1ns / 1ps
`include "fault_qualifier_heal_latch_top_assert.svh"

module fault_qualifier_heal_latch_top #(
    parameter int COUNT_WIDTH = fqhl_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  fqhl_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output fqhl_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    fqhl_pkg::cfg_wr_t cfg_wr;
    fqhl_pkg::result_t core_result;
    fqhl_pkg::result_t out_reg;
    fqhl_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              item_acc;
    logic              out_acc;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign item_stall = skid_valid_reg;
    assign item_acc   = item_valid && !skid_valid_reg;
    assign out_acc    = out_valid_reg && !result_stall;

    fqhl_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .accept (item_acc),
        .item   (item),
        .result (core_result)
    );

    // output register plus skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_acc)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (item_acc)
        begin
            if (out_valid_reg && !out_acc)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_acc)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (item_acc)
        begin
            if (out_valid_reg && !out_acc)
            begin
                skid_reg <= core_result;
            end
            else
            begin
                out_reg <= core_result;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `FQHL_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `FQHL_ASSERT_NXT(a_skid_drains_first, (skid_valid_reg && out_acc),
        (out_valid_reg && !skid_valid_reg))
    `FQHL_ASSERT_NXT(a_request_lands, (item_acc && !out_valid_reg),
        (out_valid_reg && !skid_valid_reg))

endmodule
